// ----- hdl/chmc_pkg.sv -----
package chmc_pkg;

   // Coordinate width of one axis
   localparam int unsigned COORD_W = 32;
   // Difference and product widths of the cross and area terms
   localparam int unsigned DIFF_W  = COORD_W + 1;
   localparam int unsigned PROD_W  = 2 * DIFF_W;

   // Point memory write data source
   typedef enum logic [1:0] {
      WSEL_REQ = 2'd0,
      WSEL_RD  = 2'd1,
      WSEL_KEY = 2'd2
   } pt_wsel_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MUL_CROSS_A = 2'd0,
      MUL_CROSS_B = 2'd1,
      MUL_AREA_A  = 2'd2,
      MUL_AREA_B  = 2'd3
   } mul_sel_type;

   // Accumulator operation
   typedef enum logic [2:0] {
      ACC_HOLD = 3'd0,
      ACC_CLR  = 3'd1,
      ACC_LOAD = 3'd2,
      ACC_ADD  = 3'd3,
      ACC_SUB  = 3'd4
   } acc_op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        pt_we;
      pt_wsel_type pt_wsel;
      logic        stk_we;
      logic        key_ld;
      logic        o_ld;
      logic        a_ld;
      logic        b_ld;
      logic        dif_ld;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic gt;
      logic pos;
   } stat_type;

endpackage

// ----- hdl/convex_hull_monotone_chain.sv -----
// Convex hull of up to MAX_POINTS signed Q15.16 points (monotone chain).
// Points are requested one per cycle with start while busy is low; the request
// with req_last_point set ends the set, raises busy and starts the run. Points
// beyond MAX_POINTS are dropped. The run sorts the points in place (insertion
// sort), sweeps the lower and upper chains (one shared 33x33 multiplier), sums
// the signed area and then presents each hull vertex, clockwise, for one cycle
// with rsp_valid; rsp_last_vertex marks the final one.
// The receiver cannot stall. The single read port of the point memory and the
// shared multiplier set the pace. busy drops after the final vertex.
module convex_hull_monotone_chain #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [chmc_pkg::COORD_W-1:0] req_in_x,
   input  logic signed [chmc_pkg::COORD_W-1:0] req_in_y,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   output logic signed [chmc_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [chmc_pkg::COORD_W-1:0] rsp_out_y,
   output logic                                rsp_last_vertex
);

   localparam int unsigned PW = $clog2(MAX_POINTS);
   localparam int unsigned SW = $clog2(2 * MAX_POINTS);

   chmc_pkg::cmd_type  cmd;
   chmc_pkg::stat_type stat;
   logic [PW-1:0]      pt_waddr;
   logic [PW-1:0]      pt_raddr;
   logic [SW-1:0]      stk_waddr;
   logic [SW-1:0]      stk_raddr;
   logic [PW-1:0]      stk_wdata;
   logic [PW-1:0]      stk_rd;

   chmc_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_point  (req_last_point),
      .busy        (busy),
      .strobe      (rsp_valid),
      .last_vertex (rsp_last_vertex),
      .cmd         (cmd),
      .pt_waddr    (pt_waddr),
      .pt_raddr    (pt_raddr),
      .stk_waddr   (stk_waddr),
      .stk_raddr   (stk_raddr),
      .stk_wdata   (stk_wdata),
      .stat        (stat),
      .stk_rd      (stk_rd)
   );

   chmc_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .pt_waddr  (pt_waddr),
      .pt_raddr  (pt_raddr),
      .stk_waddr (stk_waddr),
      .stk_raddr (stk_raddr),
      .stk_wdata (stk_wdata),
      .req_x     (req_in_x),
      .req_y     (req_in_y),
      .stat      (stat),
      .stk_rd    (stk_rd),
      .rd_x      (rsp_out_x),
      .rd_y      (rsp_out_y)
   );

endmodule

// ----- hdl/chmc_dp.sv -----
module chmc_dp #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                                  clock,
   input  chmc_pkg::cmd_type                     cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]         pt_waddr,
   input  logic [$clog2(MAX_POINTS)-1:0]         pt_raddr,
   input  logic [$clog2(2*MAX_POINTS)-1:0]       stk_waddr,
   input  logic [$clog2(2*MAX_POINTS)-1:0]       stk_raddr,
   input  logic [$clog2(MAX_POINTS)-1:0]         stk_wdata,
   input  logic signed [chmc_pkg::COORD_W-1:0]   req_x,
   input  logic signed [chmc_pkg::COORD_W-1:0]   req_y,
   output chmc_pkg::stat_type                    stat,
   output logic [$clog2(MAX_POINTS)-1:0]         stk_rd,
   output logic signed [chmc_pkg::COORD_W-1:0]   rd_x,
   output logic signed [chmc_pkg::COORD_W-1:0]   rd_y
);

   localparam int unsigned PW = $clog2(MAX_POINTS);
   localparam int unsigned SW = $clog2(2 * MAX_POINTS);
   localparam int unsigned CW = chmc_pkg::COORD_W;
   localparam int unsigned DW = chmc_pkg::DIFF_W;
   localparam int unsigned MW = chmc_pkg::PROD_W;
   localparam int unsigned AW = MW + 1 + SW;

   logic [2*CW-1:0]        pt_mem [MAX_POINTS];
   logic [PW-1:0]          stk_mem [2*MAX_POINTS];
   logic [2*CW-1:0]        pt_rd_ff;
   logic [PW-1:0]          stk_rd_ff;
   logic [2*CW-1:0]        pt_wdata;
   logic [2*CW-1:0]        key_ff;
   logic [2*CW-1:0]        o_ff;
   logic [2*CW-1:0]        a_ff;
   logic [2*CW-1:0]        b_ff;
   logic signed [DW-1:0]   dax_ff, day_ff, dbx_ff, dby_ff;
   logic signed [DW-1:0]   op1, op2;
   logic signed [MW-1:0]   prod_in, prod_ff;
   logic signed [AW-1:0]   prod_ext;
   logic signed [AW-1:0]   acc_in, acc_ff;
   logic signed [CW-1:0]   rx, ry, kx, ky;

   // Point memory write source
   always_comb begin
      case (cmd.pt_wsel)
         chmc_pkg::WSEL_REQ: pt_wdata = {req_x, req_y};
         chmc_pkg::WSEL_RD:  pt_wdata = pt_rd_ff;
         chmc_pkg::WSEL_KEY: pt_wdata = key_ff;
         default:            pt_wdata = key_ff;
      endcase
   end

   // Point memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
      pt_rd_ff <= pt_mem[pt_raddr];
   end

   // Hull stack memory
   always_ff @(posedge clock) begin
      if (cmd.stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   // Sort key and the three points of a test
   always_ff @(posedge clock) begin
      if (cmd.key_ld) key_ff <= pt_rd_ff;
      if (cmd.o_ld)   o_ff   <= pt_rd_ff;
      if (cmd.a_ld)   a_ff   <= pt_rd_ff;
      if (cmd.b_ld)   b_ff   <= pt_rd_ff;
   end

   // Edge vectors relative to o
   always_ff @(posedge clock) begin
      if (cmd.dif_ld) begin
         dax_ff <= DW'($signed(a_ff[2*CW-1:CW])) - DW'($signed(o_ff[2*CW-1:CW]));
         day_ff <= DW'($signed(a_ff[CW-1:0]))    - DW'($signed(o_ff[CW-1:0]));
         dbx_ff <= DW'($signed(b_ff[2*CW-1:CW])) - DW'($signed(o_ff[2*CW-1:CW]));
         dby_ff <= DW'($signed(b_ff[CW-1:0]))    - DW'($signed(o_ff[CW-1:0]));
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         chmc_pkg::MUL_CROSS_A: begin
            op1 = dax_ff;
            op2 = dby_ff;
         end
         chmc_pkg::MUL_CROSS_B: begin
            op1 = day_ff;
            op2 = dbx_ff;
         end
         chmc_pkg::MUL_AREA_A: begin
            op1 = DW'($signed(a_ff[2*CW-1:CW]));
            op2 = DW'($signed(b_ff[CW-1:0]));
         end
         chmc_pkg::MUL_AREA_B: begin
            op1 = DW'($signed(b_ff[2*CW-1:CW]));
            op2 = DW'($signed(a_ff[CW-1:0]));
         end
         default: begin
            op1 = dax_ff;
            op2 = dby_ff;
         end
      endcase
   end

   assign prod_in  = op1 * op2;
   assign prod_ext = {{(AW-MW){prod_ff[MW-1]}}, prod_ff};

   // Accumulator for cross product and area sum
   always_comb begin
      case (cmd.acc_op)
         chmc_pkg::ACC_HOLD: acc_in = acc_ff;
         chmc_pkg::ACC_CLR:  acc_in = '0;
         chmc_pkg::ACC_LOAD: acc_in = prod_ext;
         chmc_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         chmc_pkg::ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:            acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Status: sort compare and sign test
   assign rx = pt_rd_ff[2*CW-1:CW];
   assign ry = pt_rd_ff[CW-1:0];
   assign kx = key_ff[2*CW-1:CW];
   assign ky = key_ff[CW-1:0];

   assign stat.gt  = (rx > kx) || ((rx == kx) && (ry > ky));
   assign stat.pos = !acc_ff[AW-1] && (acc_ff != '0);

   assign stk_rd = stk_rd_ff;
   assign rd_x   = rx;
   assign rd_y   = ry;

endmodule

// ----- hdl/chmc_ctrl.sv -----
module chmc_ctrl #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            last_point,
   output logic                            busy,
   output logic                            strobe,
   output logic                            last_vertex,
   output chmc_pkg::cmd_type               cmd,
   output logic [$clog2(MAX_POINTS)-1:0]   pt_waddr,
   output logic [$clog2(MAX_POINTS)-1:0]   pt_raddr,
   output logic [$clog2(2*MAX_POINTS)-1:0] stk_waddr,
   output logic [$clog2(2*MAX_POINTS)-1:0] stk_raddr,
   output logic [$clog2(MAX_POINTS)-1:0]   stk_wdata,
   input  chmc_pkg::stat_type              stat,
   input  logic [$clog2(MAX_POINTS)-1:0]   stk_rd
);

   localparam int unsigned PW = $clog2(MAX_POINTS);
   localparam int unsigned CNW = $clog2(MAX_POINTS + 1);
   localparam int unsigned SW = $clog2(2 * MAX_POINTS);
   localparam int unsigned DPW = $clog2(2 * MAX_POINTS + 1);

   typedef enum logic [27:0] {
      ST_IDLE   = 28'h0000001,
      ST_S_INIT = 28'h0000002,
      ST_S_KEY  = 28'h0000004,
      ST_S_CMP  = 28'h0000008,
      ST_S_PUT  = 28'h0000010,
      ST_H_TEST = 28'h0000020,
      ST_H_RO   = 28'h0000040,
      ST_H_RA   = 28'h0000080,
      ST_H_RB   = 28'h0000100,
      ST_H_LB   = 28'h0000200,
      ST_H_DIF  = 28'h0000400,
      ST_H_M1   = 28'h0000800,
      ST_H_M2   = 28'h0001000,
      ST_H_M3   = 28'h0002000,
      ST_H_CHK  = 28'h0004000,
      ST_H_PUSH = 28'h0008000,
      ST_H_FIN  = 28'h0010000,
      ST_A_R0   = 28'h0020000,
      ST_A_R1   = 28'h0040000,
      ST_A_R2   = 28'h0080000,
      ST_A_R3   = 28'h0100000,
      ST_A_M1   = 28'h0200000,
      ST_A_M2   = 28'h0400000,
      ST_A_M3   = 28'h0800000,
      ST_A_DEC  = 28'h1000000,
      ST_E_RS   = 28'h2000000,
      ST_E_RP   = 28'h4000000,
      ST_E_OUT  = 28'h8000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CNW-1:0]  cnt_ff, cnt_in;
   logic [CNW-1:0]  i_ff, i_in;
   logic [PW-1:0]   j_ff, j_in;
   logic [DPW-1:0]  dep_ff, dep_in;
   logic [DPW-1:0]  low_ff, low_in;
   logic [DPW-1:0]  k_ff, k_in;
   logic            up_ff, up_in;
   logic            rev_ff, rev_in;
   logic [DPW-1:0]  k_next;
   logic [DPW-1:0]  emit_idx;

   assign k_next   = k_ff + DPW'(1);
   assign emit_idx = rev_ff ? (dep_ff - DPW'(1) - k_ff) : k_ff;

   // Sequencer: load, sort, lower/upper sweep, area, emit
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      dep_in    = dep_ff;
      low_in    = low_ff;
      k_in      = k_ff;
      up_in     = up_ff;
      rev_in    = rev_ff;
      cmd       = '0;
      cmd.pt_wsel = chmc_pkg::WSEL_REQ;
      cmd.mul_sel = chmc_pkg::MUL_CROSS_A;
      cmd.acc_op  = chmc_pkg::ACC_HOLD;
      pt_waddr  = j_ff;
      pt_raddr  = stk_rd;
      stk_waddr = dep_ff[SW-1:0];
      stk_raddr = dep_ff[SW-1:0];
      stk_wdata = i_ff[PW-1:0];
      strobe    = 1'b0;
      last_vertex = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cnt_ff < CNW'(MAX_POINTS)) begin
                  cmd.pt_we = 1'b1;
                  pt_waddr  = cnt_ff[PW-1:0];
                  cnt_in    = cnt_ff + CNW'(1);
               end
               if (last_point) begin
                  i_in     = CNW'(1);
                  state_in = ST_S_INIT;
               end
            end
         end

         // insertion sort
         ST_S_INIT: begin
            if (i_ff >= cnt_ff) begin
               i_in     = '0;
               dep_in   = '0;
               up_in    = 1'b0;
               state_in = ST_H_TEST;
            end else begin
               pt_raddr = i_ff[PW-1:0];
               j_in     = i_ff[PW-1:0];
               state_in = ST_S_KEY;
            end
         end
         ST_S_KEY: begin
            cmd.key_ld = 1'b1;
            pt_raddr   = j_ff - PW'(1);
            state_in   = ST_S_CMP;
         end
         ST_S_CMP: begin
            if (stat.gt) begin
               cmd.pt_we   = 1'b1;
               cmd.pt_wsel = chmc_pkg::WSEL_RD;
               j_in        = j_ff - PW'(1);
               pt_raddr    = j_ff - PW'(2);
               if (j_ff == PW'(1)) begin
                  state_in = ST_S_PUT;
               end
            end else begin
               state_in = ST_S_PUT;
            end
         end
         ST_S_PUT: begin
            cmd.pt_we   = 1'b1;
            cmd.pt_wsel = chmc_pkg::WSEL_KEY;
            i_in        = i_ff + CNW'(1);
            state_in    = ST_S_INIT;
         end

         // hull sweeps
         ST_H_TEST: begin
            if (up_ff ? (dep_ff > low_ff) : (dep_ff >= DPW'(2))) begin
               stk_raddr = SW'(dep_ff - DPW'(2));
               state_in  = ST_H_RO;
            end else begin
               state_in  = ST_H_PUSH;
            end
         end
         ST_H_RO: begin
            stk_raddr = SW'(dep_ff - DPW'(1));
            state_in  = ST_H_RA;
         end
         ST_H_RA: begin
            cmd.o_ld = 1'b1;
            state_in = ST_H_RB;
         end
         ST_H_RB: begin
            cmd.a_ld = 1'b1;
            pt_raddr = i_ff[PW-1:0];
            state_in = ST_H_LB;
         end
         ST_H_LB: begin
            cmd.b_ld = 1'b1;
            state_in = ST_H_DIF;
         end
         ST_H_DIF: begin
            cmd.dif_ld = 1'b1;
            state_in   = ST_H_M1;
         end
         ST_H_M1: begin
            cmd.mul_sel = chmc_pkg::MUL_CROSS_A;
            state_in    = ST_H_M2;
         end
         ST_H_M2: begin
            cmd.mul_sel = chmc_pkg::MUL_CROSS_B;
            cmd.acc_op  = chmc_pkg::ACC_LOAD;
            state_in    = ST_H_M3;
         end
         ST_H_M3: begin
            cmd.acc_op = chmc_pkg::ACC_SUB;
            state_in   = ST_H_CHK;
         end
         ST_H_CHK: begin
            if (!stat.pos) begin
               dep_in   = dep_ff - DPW'(1);
               state_in = ST_H_TEST;
            end else begin
               state_in = ST_H_PUSH;
            end
         end
         ST_H_PUSH: begin
            cmd.stk_we = 1'b1;
            dep_in     = dep_ff + DPW'(1);
            if (!up_ff) begin
               if (i_ff + CNW'(1) == cnt_ff) begin
                  low_in = dep_ff + DPW'(1);
                  if (cnt_ff >= CNW'(2)) begin
                     i_in     = cnt_ff - CNW'(2);
                     up_in    = 1'b1;
                     state_in = ST_H_TEST;
                  end else begin
                     state_in = ST_H_FIN;
                  end
               end else begin
                  i_in     = i_ff + CNW'(1);
                  state_in = ST_H_TEST;
               end
            end else if (i_ff == '0) begin
               state_in = ST_H_FIN;
            end else begin
               i_in     = i_ff - CNW'(1);
               state_in = ST_H_TEST;
            end
         end
         ST_H_FIN: begin
            // drop the closing duplicate
            if (dep_ff > DPW'(1)) begin
               dep_in = dep_ff - DPW'(1);
            end
            cmd.acc_op = chmc_pkg::ACC_CLR;
            k_in       = '0;
            state_in   = ST_A_R0;
         end

         // signed area over the closed hull
         ST_A_R0: begin
            if (k_ff == dep_ff) begin
               state_in = ST_A_DEC;
            end else begin
               stk_raddr = k_ff[SW-1:0];
               state_in  = ST_A_R1;
            end
         end
         ST_A_R1: begin
            stk_raddr = (k_next == dep_ff) ? '0 : k_next[SW-1:0];
            state_in  = ST_A_R2;
         end
         ST_A_R2: begin
            cmd.a_ld = 1'b1;
            state_in = ST_A_R3;
         end
         ST_A_R3: begin
            cmd.b_ld = 1'b1;
            state_in = ST_A_M1;
         end
         ST_A_M1: begin
            cmd.mul_sel = chmc_pkg::MUL_AREA_A;
            state_in    = ST_A_M2;
         end
         ST_A_M2: begin
            cmd.mul_sel = chmc_pkg::MUL_AREA_B;
            cmd.acc_op  = chmc_pkg::ACC_ADD;
            state_in    = ST_A_M3;
         end
         ST_A_M3: begin
            cmd.acc_op = chmc_pkg::ACC_SUB;
            k_in       = k_next;
            state_in   = ST_A_R0;
         end
         ST_A_DEC: begin
            rev_in   = stat.pos;
            k_in     = '0;
            state_in = ST_E_RS;
         end

         // emit vertices
         ST_E_RS: begin
            stk_raddr = emit_idx[SW-1:0];
            state_in  = ST_E_RP;
         end
         ST_E_RP: begin
            state_in = ST_E_OUT;
         end
         ST_E_OUT: begin
            strobe      = 1'b1;
            last_vertex = (k_next == dep_ff);
            if (k_next == dep_ff) begin
               cnt_in   = '0;
               dep_in   = '0;
               state_in = ST_IDLE;
            end else begin
               k_in     = k_next;
               state_in = ST_E_RS;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         dep_ff   <= '0;
         low_ff   <= '0;
         k_ff     <= '0;
         up_ff    <= 1'b0;
         rev_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         dep_ff   <= dep_in;
         low_ff   <= low_in;
         k_ff     <= k_in;
         up_ff    <= up_in;
         rev_ff   <= rev_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNW'(MAX_POINTS))
      else $error("point count above capacity");

   a_dep_bound: assert property (@(posedge clock) disable iff (reset)
      dep_ff < DPW'(2 * MAX_POINTS))
      else $error("hull stack overflow");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      strobe && last_vertex |=> !busy)
      else $error("still busy after final vertex");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy && last_point |=> busy && !strobe)
      else $error("hull run did not start");
`endif

endmodule
